[rtl/i2cms_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and codes for the i2c master transaction sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  localparam logic [7:0] ST_MASK      = 8'hF8;
  localparam logic [7:0] RW_READ_BIT  = 8'h01;

  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_RSTART    = 8'h10;
  localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
  localparam logic [7:0] ST_DATAW_ACK = 8'h28;
  localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
  localparam logic [7:0] ST_DATAR_ACK = 8'h50;
  localparam logic [7:0] ST_DATAR_NAK = 8'h58;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_START   = 3'd1;
  localparam logic [2:0] ACT_SEND    = 3'd2;
  localparam logic [2:0] ACT_RD_ACK  = 3'd3;
  localparam logic [2:0] ACT_RD_NACK = 3'd4;
  localparam logic [2:0] ACT_STOP    = 3'd5;
  localparam logic [2:0] ACT_RESTART = 3'd6;

  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_STATUS = 1'b1;

  localparam logic [1:0] MODE_WRITE     = 2'd0;
  localparam logic [1:0] MODE_READ      = 2'd1;
  localparam logic [1:0] MODE_REG_WRITE = 2'd2;
  localparam logic [1:0] MODE_REG_READ  = 2'd3;

  typedef struct packed {
    logic        command;
    logic [1:0]  mode;
    logic [6:0]  address;
    logic [7:0]  reg_index;
    logic [15:0] length;
    logic [7:0]  status_code;
    logic [7:0]  rx_byte;
    logic [7:0]  tx_byte;
  } item_t;

  typedef struct packed {
    logic [2:0] bus_action;
    logic [7:0] bus_byte;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       tx_consumed;
    logic       done_res;
    logic       error;
    logic       busy_res;
  } result_t;

endpackage

[rtl/i2c_master_transaction_sequencer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer_unit
// Sequences interrupt-style i2c master transactions, one bus action per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries either a start transaction
//   (command 0: mode, address, reg_index, length) or a bus status event
//   (command 1: status_code, rx_byte, tx_byte). Every input transaction gives
//   exactly one result on the output channel (out_valid / out_stall): the bus
//   action to perform, the byte to send, received data, tx_consumed, done_res,
//   error and busy_res.
//   Path: an input register, then the status decode and counter update
//   feeding the result register. Throughput is one transaction per cycle
//   while not stalled; the decode is a single pass over the registered item.
//   A start arriving while a transaction is busy is answered with no action.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more transaction; in_stall rises only while both
//   registers are full and out_stall is high.
//   Reset clears the valids and the transaction state (idle, no handler).
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [1:0]  mode,
  input  logic [6:0]  address,
  input  logic [7:0]  reg_index,
  input  logic [15:0] length,
  input  logic [7:0]  status_code,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  tx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  bus_action,
  output logic [7:0]  bus_byte,
  output logic        rx_valid,
  output logic [7:0]  rx_data,
  output logic        tx_consumed,
  output logic        done_res,
  output logic        error,
  output logic        busy_res
);
  import i2cms_pkg::*;

  logic    s1_valid;
  item_t   s1_item;
  logic    advance;
  result_t res;
  result_t out_res;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_item <= '{command, mode, address, reg_index, length,
                   status_code, rx_byte, tx_byte};
    end
  end

  i2cms_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (s1_item),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= s1_valid;
    end
    if (advance) begin
      out_res <= res;
    end
  end

  assign bus_action  = out_res.bus_action;
  assign bus_byte    = out_res.bus_byte;
  assign rx_valid    = out_res.rx_valid;
  assign rx_data     = out_res.rx_data;
  assign tx_consumed = out_res.tx_consumed;
  assign done_res    = out_res.done_res;
  assign error       = out_res.error;
  assign busy_res    = out_res.busy_res;

  // completion and abort both end with stop and leave the block idle
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (done_res || error) |-> bus_action == ACT_STOP && !busy_res && !(done_res && error))
    else $error("finish without stop or still busy");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && tx_consumed |-> bus_action == ACT_SEND && !rx_valid)
    else $error("payload consumed without send");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && bus_action == ACT_START |-> busy_res)
    else $error("start issued but not busy");

  // input side only backs up when the result register is held
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && s1_valid)
    else $error("input stalled with room downstream");

endmodule

[rtl/i2cms_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_core
// Transaction state and the status decode that picks one bus action per item.
// ----------------------------------------------------------------------------
module i2cms_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  i2cms_pkg::item_t  item,
  output i2cms_pkg::result_t res
);
  import i2cms_pkg::*;

  logic        busy;
  logic [1:0]  active_mode;
  logic        armed;
  logic [6:0]  target_address;
  logic [7:0]  register_byte;
  logic [15:0] byte_total;
  logic [15:0] byte_count;

  logic        busy_next;
  logic [1:0]  active_mode_next;
  logic        armed_next;
  logic [6:0]  target_address_next;
  logic [7:0]  register_byte_next;
  logic [15:0] byte_total_next;
  logic [15:0] byte_count_next;

  logic [7:0]  st;
  logic [7:0]  addr_w;
  logic [7:0]  addr_r;
  logic [15:0] cnt_inc;
  logic        rd_ack_now;
  logic        rd_ack_after;
  logic        wr_done;

  assign st      = item.status_code & ST_MASK;
  assign addr_w  = {target_address, 1'b0};
  assign addr_r  = addr_w | RW_READ_BIT;
  assign cnt_inc = byte_count + 16'd1;
  // read requests compare count + 1 against total without wrapping
  assign rd_ack_now   = ({1'b0, byte_count} + 17'd1) < {1'b0, byte_total};
  assign rd_ack_after = ({1'b0, cnt_inc} + 17'd1) < {1'b0, byte_total};
  assign wr_done      = byte_count >= byte_total;

  always_comb begin
    res                 = '0;
    busy_next           = busy;
    active_mode_next    = active_mode;
    armed_next          = armed;
    target_address_next = target_address;
    register_byte_next  = register_byte;
    byte_total_next     = byte_total;
    byte_count_next     = byte_count;

    if (item.command == CMD_START) begin
      if (!busy) begin
        busy_next           = 1'b1;
        active_mode_next    = item.mode;
        armed_next          = 1'b1;
        target_address_next = item.address;
        register_byte_next  = item.reg_index;
        byte_total_next     = item.length;
        byte_count_next     = '0;
        res.bus_action      = ACT_START;
      end
    end else if (armed) begin
      unique case (active_mode)
        MODE_WRITE, MODE_REG_WRITE: begin
          if (st == ST_START || st == ST_RSTART) begin
            res.bus_action = ACT_SEND;
            res.bus_byte   = addr_w;
          end else if (st == ST_SLAW_ACK && active_mode == MODE_REG_WRITE) begin
            res.bus_action = ACT_SEND;
            res.bus_byte   = register_byte;
          end else if (st == ST_SLAW_ACK || st == ST_DATAW_ACK) begin
            if (wr_done) begin
              res.bus_action = ACT_STOP;
              res.done_res   = 1'b1;
              busy_next      = 1'b0;
            end else begin
              res.bus_action  = ACT_SEND;
              res.bus_byte    = item.tx_byte;
              res.tx_consumed = 1'b1;
              byte_count_next = cnt_inc;
            end
          end else begin
            res.bus_action = ACT_STOP;
            res.error      = 1'b1;
            busy_next      = 1'b0;
          end
        end
        MODE_READ, MODE_REG_READ: begin
          // register read: write phase first, then repeated start into read
          if (st == ST_START && active_mode == MODE_REG_READ) begin
            res.bus_action = ACT_SEND;
            res.bus_byte   = addr_w;
          end else if (st == ST_SLAW_ACK && active_mode == MODE_REG_READ) begin
            res.bus_action = ACT_SEND;
            res.bus_byte   = register_byte;
          end else if (st == ST_DATAW_ACK && active_mode == MODE_REG_READ) begin
            res.bus_action = ACT_RESTART;
          end else if (st == ST_START || st == ST_RSTART) begin
            res.bus_action = ACT_SEND;
            res.bus_byte   = addr_r;
          end else if (st == ST_SLAR_ACK) begin
            res.bus_action = rd_ack_now ? ACT_RD_ACK : ACT_RD_NACK;
          end else if (st == ST_DATAR_ACK) begin
            res.rx_valid    = 1'b1;
            res.rx_data     = item.rx_byte;
            byte_count_next = cnt_inc;
            res.bus_action  = rd_ack_after ? ACT_RD_ACK : ACT_RD_NACK;
          end else if (st == ST_DATAR_NAK) begin
            res.rx_valid    = 1'b1;
            res.rx_data     = item.rx_byte;
            byte_count_next = cnt_inc;
            res.bus_action  = ACT_STOP;
            res.done_res    = 1'b1;
            busy_next       = 1'b0;
          end else begin
            res.bus_action = ACT_STOP;
            res.error      = 1'b1;
            busy_next      = 1'b0;
          end
        end
        default: begin
          res.bus_action = ACT_NONE;
        end
      endcase
    end
    res.busy_res = busy_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      active_mode    <= MODE_WRITE;
      armed          <= 1'b0;
      target_address <= '0;
      register_byte  <= '0;
      byte_total     <= '0;
      byte_count     <= '0;
    end else if (fire) begin
      busy           <= busy_next;
      active_mode    <= active_mode_next;
      armed          <= armed_next;
      target_address <= target_address_next;
      register_byte  <= register_byte_next;
      byte_total     <= byte_total_next;
      byte_count     <= byte_count_next;
    end
  end

endmodule
